### sv/bgsf_pkg.sv
package bgsf_pkg;

    localparam int ADC_BITS   = 10;
    localparam int FRAC_BITS  = 8;
    localparam int SMOOTH_W   = ADC_BITS + FRAC_BITS;
    localparam int ALPHA_W    = 9;
    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

    localparam logic [MS_W-1:0]    GAP_RESET      = MS_W'(300);
    localparam logic [MS_W-1:0]    LONG_RESET     = MS_W'(800);
    localparam logic [MS_W-1:0]    LONGLONG_RESET = MS_W'(3000);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET    = ALPHA_W'(26);

    typedef enum logic [1:0] {
        REG_GAP      = 2'd0,
        REG_LONG     = 2'd1,
        REG_LONGLONG = 2'd2,
        REG_ALPHA    = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_PRESS    = 4'b0010,
        PH_LONG     = 4'b0100,
        PH_LONGLONG = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [MS_W-1:0]    double_click_gap_ms;
        logic [MS_W-1:0]    long_press_ms;
        logic [MS_W-1:0]    long_long_press_ms;
        logic [ALPHA_W-1:0] smoothing_alpha;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]   time_ms;
        logic                button_down;
        logic [ADC_BITS-1:0] knob_raw;
        logic [ADC_BITS-1:0] light_raw;
    } t_in;

    typedef struct packed {
        logic                single_click;
        logic                double_click;
        logic                long_press;
        logic                long_long_press;
        logic                held_now;
        logic [ADC_BITS-1:0] knob_level;
        logic [ADC_BITS-1:0] light_level;
    } t_out;

    typedef struct packed {
        logic single_click;
        logic double_click;
        logic long_press;
        logic long_long_press;
    } t_press_flags;

endpackage

### sv/bgsf_press.sv
module bgsf_press (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [bgsf_pkg::TIME_W-1:0] i_time,
    input  logic                        i_held,
    input  bgsf_pkg::t_cfg              i_cfg,
    output bgsf_pkg::t_press_flags      o_flags
);

    bgsf_pkg::t_phase                r_phase, n_phase;
    logic [bgsf_pkg::TIME_W-1:0]     r_start, n_start;
    logic [bgsf_pkg::TIME_W-1:0]     r_release, n_release;
    logic [1:0]                      r_count, n_count;

    logic [bgsf_pkg::TIME_W-1:0]     w_held_for;
    logic [bgsf_pkg::TIME_W-1:0]     w_quiet;
    logic                            w_long_hit;
    logic                            w_longlong_hit;
    logic                            w_gap_hit;

    assign w_held_for     = i_time - r_start;
    assign w_quiet        = i_time - r_release;
    assign w_long_hit     = w_held_for >= bgsf_pkg::TIME_W'(i_cfg.long_press_ms);
    assign w_longlong_hit = w_held_for >= bgsf_pkg::TIME_W'(i_cfg.long_long_press_ms);
    assign w_gap_hit      = w_quiet >= bgsf_pkg::TIME_W'(i_cfg.double_click_gap_ms);

    always_comb begin
        n_phase   = r_phase;
        n_start   = r_start;
        n_release = r_release;
        n_count   = r_count;
        o_flags   = '0;
        case (r_phase)
            bgsf_pkg::PH_IDLE: begin
                if (i_held) begin
                    n_phase = bgsf_pkg::PH_PRESS;
                    n_start = i_time;
                end else if (r_count != 2'd0 && w_gap_hit) begin
                    o_flags.single_click = (r_count == 2'd1);
                    o_flags.double_click = (r_count != 2'd1);
                    n_count = 2'd0;
                end
            end
            bgsf_pkg::PH_PRESS: begin
                if (!i_held) begin
                    if (!w_long_hit) begin
                        if (r_count != 2'd3) begin
                            n_count = r_count + 2'd1;
                        end
                        n_release = i_time;
                    end
                    n_phase = bgsf_pkg::PH_IDLE;
                end else if (w_long_hit) begin
                    n_phase            = bgsf_pkg::PH_LONG;
                    o_flags.long_press = 1'b1;
                end
            end
            bgsf_pkg::PH_LONG: begin
                if (!i_held) begin
                    n_phase = bgsf_pkg::PH_IDLE;
                end else if (w_longlong_hit) begin
                    n_phase                 = bgsf_pkg::PH_LONGLONG;
                    o_flags.long_long_press = 1'b1;
                end
            end
            default: begin
                if (!i_held) begin
                    n_phase = bgsf_pkg::PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bgsf_pkg::PH_IDLE;
            r_start   <= '0;
            r_release <= '0;
            r_count   <= 2'd0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_start   <= n_start;
            r_release <= n_release;
            r_count   <= n_count;
        end
    end

    a_click_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |-> !(o_flags.single_click && o_flags.double_click))
        else $error("single and double click in one beat");

    a_long_enters_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_flags.long_press) |=> (r_phase == bgsf_pkg::PH_LONG))
        else $error("long press pulse without entering long phase");

    a_release_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_held) |=> (r_phase == bgsf_pkg::PH_IDLE))
        else $error("release did not return to idle");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (o_flags.single_click || o_flags.double_click)) |=> (r_count == 2'd0))
        else $error("click count not cleared after report");

endmodule

### sv/bgsf_smooth.sv
module bgsf_smooth (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [bgsf_pkg::ADC_BITS-1:0] i_raw,
    input  logic [bgsf_pkg::ALPHA_W-1:0]  i_alpha,
    output logic [bgsf_pkg::ADC_BITS-1:0] o_level
);

    localparam int DIFF_W = bgsf_pkg::SMOOTH_W + 1;
    localparam int PROD_W = DIFF_W + bgsf_pkg::ALPHA_W + 1;

    logic                            r_primed;
    logic [bgsf_pkg::SMOOTH_W-1:0]   r_smooth, n_smooth;

    logic [bgsf_pkg::SMOOTH_W-1:0]   w_target;
    logic [bgsf_pkg::SMOOTH_W-1:0]   w_base;
    logic [bgsf_pkg::ALPHA_W-1:0]    w_alpha;
    logic signed [DIFF_W-1:0]        w_diff;
    logic signed [PROD_W-1:0]        w_prod;
    logic signed [PROD_W-1:0]        w_round;
    logic [bgsf_pkg::SMOOTH_W-1:0]   w_adj;

    // s' = s + round(a * (target - s) / 256), same as the weighted sum
    assign w_target = {i_raw, {bgsf_pkg::FRAC_BITS{1'b0}}};
    assign w_base   = r_primed ? r_smooth : w_target;
    assign w_alpha  = (i_alpha > bgsf_pkg::ALPHA_ONE) ? bgsf_pkg::ALPHA_ONE : i_alpha;
    assign w_diff   = $signed({1'b0, w_target}) - $signed({1'b0, w_base});
    assign w_prod   = $signed({1'b0, w_alpha}) * w_diff;
    assign w_round  = w_prod + PROD_W'(signed'(128));
    assign w_adj    = w_round[bgsf_pkg::FRAC_BITS +: bgsf_pkg::SMOOTH_W];
    assign n_smooth = w_base + w_adj;
    assign o_level  = n_smooth[bgsf_pkg::FRAC_BITS +: bgsf_pkg::ADC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_smooth <= '0;
        end else if (i_en) begin
            r_primed <= 1'b1;
            r_smooth <= n_smooth;
        end
    end

endmodule

### sv/button_gesture_and_sensor_filter_core.sv
// Button gesture detector with two smoothed sensor channels. Every input beat is one
// poll tick and yields exactly one result beat, in the cycle after it is taken; a new tick
// is taken every cycle while the result side keeps up, as the press state machine, the
// click counter and the two filters each update as the tick is taken and the result sits
// in one output register. Time differences wrap modulo 2^32; a press released before
// long_press_ms counts as a click (saturating at three), and the click count is reported
// as single or double once double_click_gap_ms has passed since the last release.
// The filters apply s' = s + round(alpha * (raw*256 - s) / 256), alpha in Q1.8 capped
// at 256; the first tick after reset loads the raw samples. Registers at byte offsets
// 0x0 gap, 0x4 long press, 0x8 long-long press, 0xC alpha; write them only when idle.
module button_gesture_and_sensor_filter_core (
    input  logic            i_clk,
    input  logic            i_rst_n,

    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bgsf_pkg::t_in   i_in_data,

    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bgsf_pkg::t_out  o_out_data,

    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    bgsf_pkg::t_cfg          r_cfg;
    bgsf_pkg::t_out          r_out, n_out;
    logic                    r_out_valid;

    logic                    w_accept;
    logic                    w_wr;
    bgsf_pkg::t_reg_idx      w_idx;
    bgsf_pkg::t_press_flags  w_flags;
    logic [bgsf_pkg::ADC_BITS-1:0] w_knob;
    logic [bgsf_pkg::ADC_BITS-1:0] w_light;

    assign pready = 1'b1;
    assign w_idx  = bgsf_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.double_click_gap_ms <= bgsf_pkg::GAP_RESET;
            r_cfg.long_press_ms       <= bgsf_pkg::LONG_RESET;
            r_cfg.long_long_press_ms  <= bgsf_pkg::LONGLONG_RESET;
            r_cfg.smoothing_alpha     <= bgsf_pkg::ALPHA_RESET;
        end else if (w_wr) begin
            case (w_idx)
                bgsf_pkg::REG_GAP:      r_cfg.double_click_gap_ms <= pwdata[15:0];
                bgsf_pkg::REG_LONG:     r_cfg.long_press_ms       <= pwdata[15:0];
                bgsf_pkg::REG_LONGLONG: r_cfg.long_long_press_ms  <= pwdata[15:0];
                bgsf_pkg::REG_ALPHA:    r_cfg.smoothing_alpha     <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            bgsf_pkg::REG_GAP:      prdata = 32'(r_cfg.double_click_gap_ms);
            bgsf_pkg::REG_LONG:     prdata = 32'(r_cfg.long_press_ms);
            bgsf_pkg::REG_LONGLONG: prdata = 32'(r_cfg.long_long_press_ms);
            bgsf_pkg::REG_ALPHA:    prdata = 32'(r_cfg.smoothing_alpha);
            default:                prdata = '0;
        endcase
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    bgsf_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_accept),
        .i_time  (i_in_data.time_ms),
        .i_held  (i_in_data.button_down),
        .i_cfg   (r_cfg),
        .o_flags (w_flags)
    );

    bgsf_smooth u_knob (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_accept),
        .i_raw   (i_in_data.knob_raw),
        .i_alpha (r_cfg.smoothing_alpha),
        .o_level (w_knob)
    );

    bgsf_smooth u_light (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_accept),
        .i_raw   (i_in_data.light_raw),
        .i_alpha (r_cfg.smoothing_alpha),
        .o_level (w_light)
    );

    always_comb begin
        n_out.single_click    = w_flags.single_click;
        n_out.double_click    = w_flags.double_click;
        n_out.long_press      = w_flags.long_press;
        n_out.long_long_press = w_flags.long_long_press;
        n_out.held_now        = i_in_data.button_down;
        n_out.knob_level      = w_knob;
        n_out.light_level     = w_light;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
